// ===== hw/rtl/tadc_pkg.sv =====
// ----------------------------------------------------------------------------
// tadc_pkg: shared constants, types and helpers for the thermistor converter
// Fixed-point widths, register codes, pipeline stage payloads, and the
// per-stage arithmetic of the log2 unit.
// ----------------------------------------------------------------------------
package tadc_pkg;

  // Converter and fixed-point widths
  localparam int AdcBits  = 12;
  localparam int FracBits = 24;
  localparam int ExpW     = $clog2(AdcBits + 1);
  localparam int LogW     = ExpW + FracBits;
  localparam int MantW    = 31;
  localparam int SqW      = 2 * MantW;

  // Register and datapath widths
  localparam int BetaW    = 14;
  localparam int T0W      = 16;
  localparam int BkW      = 21;                 // beta * 100
  localparam int TlW      = T0W + LogW + 2;     // T0 * ln(r), signed
  localparam int DqW      = TlW + 2;            // denominator, signed
  localparam int NbW      = T0W + BkW;          // T0 * beta * 100
  localparam int NumW     = NbW + FracBits + 1; // rounded numerator
  localparam int QW       = 18;                 // quotient incl. overflow bit
  localparam int RemW     = 64;
  localparam int TempW    = 18;
  localparam int ChW      = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // Constants
  localparam logic [31:0] Ln2Q32      = 32'd2977044472;
  localparam logic [BetaW-1:0] BetaReset = BetaW'(3435);
  localparam logic [T0W-1:0]   T0Reset   = T0W'(29815);
  localparam int KelvinOffset = 27315;
  localparam int TempMax      = 100000;
  localparam int TempMin      = -27315;
  localparam int TkMax        = TempMax + KelvinOffset;

  // Cycles from an accepted beat to its result strobe
  localparam int PipeDepth = 1 + (FracBits + 1) + 4 + (QW + 1) + 1;

  // Register index codes
  typedef enum logic [CfgIdxW-1:0] {
    CfgBeta = 2'd0,
    CfgT0   = 2'd1
  } cfg_reg_t;

  // Payload of one log2 stage, both lanes
  typedef struct packed {
    logic [MantW-1:0] m_c;
    logic [MantW-1:0] m_d;
    logic [LogW-1:0]  f_c;
    logic [LogW-1:0]  f_d;
    logic             zero;
    logic [ChW-1:0]   ch;
  } log_stage_t;

  // Payload of one divider stage
  typedef struct packed {
    logic [RemW-1:0]  r;
    logic [DqW-2:0]   dq;
    logic [QW-1:0]    q;
    logic             zero;
    logic             dpos;
    logic [ChW-1:0]   ch;
  } div_stage_t;

  // Find the exponent and left-justify into Q1.30: {e, m}
  function automatic logic [ExpW+MantW-1:0] log_norm(input logic [AdcBits:0] x);
    logic [ExpW-1:0]  e;
    logic [MantW-1:0] m;
    e = '0;
    for (int i = 0; i <= AdcBits; i++) begin
      if (x[i]) e = ExpW'(i);
    end
    m = MantW'(x) << (MantW - 1 - int'(e));
    return {e, m};
  endfunction

  // One squaring step of the log2 mantissa: {fraction bit, next mantissa}
  function automatic logic [MantW:0] log_step(input logic [MantW-1:0] m);
    logic [SqW-1:0]   p;
    logic [MantW:0]   s;
    p = SqW'(m) * SqW'(m);
    s = p[SqW-1:MantW-1];
    return s[MantW] ? {1'b1, s[MantW:1]} : {1'b0, s[MantW-1:0]};
  endfunction

endpackage

// ===== hw/rtl/thermistor_adc_to_temperature.sv =====
// ----------------------------------------------------------------------------
// thermistor_adc_to_temperature: NTC beta-equation temperature converter
// Converts a divider ADC code into hundredths of a degree Celsius with a
// fully pipelined log2, ln scaling, beta equation and restoring divider.
// ----------------------------------------------------------------------------
// One beat is taken every cycle while start is high (busy never rises), and
// each result appears on a one-cycle done strobe, in order. The pipe holds
// the 24 squaring stages of the log2 unit and the 18 one-bit stages of the
// divider. There is no back-pressure: the receiver must take every done
// beat. A code of zero or a temperature outside -273.15..1000.00 C raises
// range_error with the result saturated. Write beta and T0 only while no
// beat is in flight.

module thermistor_adc_to_temperature (
  input  logic                           clk,
  input  logic                           rst,
  // command side
  input  logic                           start,
  output logic                           busy,
  input  logic [tadc_pkg::AdcBits-1:0]   adc_code,
  input  logic [tadc_pkg::ChW-1:0]       channel,
  // result side
  output logic                           done,
  output logic signed [tadc_pkg::TempW-1:0] temp_centi_c,
  output logic [tadc_pkg::ChW-1:0]       channel_out,
  output logic                           range_error,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tadc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [tadc_pkg::CfgDataW-1:0]  cfg_data
);

  localparam int FracBits = tadc_pkg::FracBits;
  localparam int QW       = tadc_pkg::QW;
  localparam int LogW     = tadc_pkg::LogW;

  logic [tadc_pkg::BetaW-1:0] beta;
  logic [tadc_pkg::T0W-1:0]   t0;

  // Pipeline never stalls
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      beta <= tadc_pkg::BetaReset;
      t0   <= tadc_pkg::T0Reset;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == tadc_pkg::CfgBeta) beta <= cfg_data[tadc_pkg::BetaW-1:0];
      if (cfg_index == tadc_pkg::CfgT0)   t0   <= cfg_data[tadc_pkg::T0W-1:0];
    end
  end

  // Input stage: capture code and its complement
  logic                      in_v;
  logic [tadc_pkg::AdcBits:0] in_c, in_d;
  logic                      in_zero;
  logic [tadc_pkg::ChW-1:0]  in_ch;

  always_ff @(posedge clk) begin
    if (rst) in_v <= 1'b0;
    else     in_v <= start && !busy;
  end

  always_ff @(posedge clk) begin
    in_c    <= {1'b0, adc_code};
    in_d    <= ((tadc_pkg::AdcBits+1)'(1) << tadc_pkg::AdcBits) - {1'b0, adc_code};
    in_zero <= (adc_code == '0);
    in_ch   <= channel;
  end

  // Log2 pipeline: normalize, then one squaring per stage
  tadc_pkg::log_stage_t lg   [0:FracBits];
  logic [FracBits:0]    lg_v;
  logic [tadc_pkg::ExpW+tadc_pkg::MantW-1:0] nrm_c, nrm_d;

  assign nrm_c = tadc_pkg::log_norm(in_c);
  assign nrm_d = tadc_pkg::log_norm(in_d);

  always_ff @(posedge clk) begin
    if (rst) lg_v[0] <= 1'b0;
    else     lg_v[0] <= in_v;
  end

  always_ff @(posedge clk) begin
    lg[0].m_c  <= nrm_c[tadc_pkg::MantW-1:0];
    lg[0].m_d  <= nrm_d[tadc_pkg::MantW-1:0];
    lg[0].f_c  <= LogW'(nrm_c[tadc_pkg::ExpW+tadc_pkg::MantW-1:tadc_pkg::MantW]);
    lg[0].f_d  <= LogW'(nrm_d[tadc_pkg::ExpW+tadc_pkg::MantW-1:tadc_pkg::MantW]);
    lg[0].zero <= in_zero;
    lg[0].ch   <= in_ch;
  end

  for (genvar k = 1; k <= FracBits; k++) begin : g_log
    logic [tadc_pkg::MantW:0] sc, sd;
    assign sc = tadc_pkg::log_step(lg[k-1].m_c);
    assign sd = tadc_pkg::log_step(lg[k-1].m_d);

    always_ff @(posedge clk) begin
      if (rst) lg_v[k] <= 1'b0;
      else     lg_v[k] <= lg_v[k-1];
    end

    // Shift in one fraction bit per lane
    always_ff @(posedge clk) begin
      lg[k].m_c  <= sc[tadc_pkg::MantW-1:0];
      lg[k].m_d  <= sd[tadc_pkg::MantW-1:0];
      lg[k].f_c  <= {lg[k-1].f_c[LogW-2:0], sc[tadc_pkg::MantW]};
      lg[k].f_d  <= {lg[k-1].f_d[LogW-2:0], sd[tadc_pkg::MantW]};
      lg[k].zero <= lg[k-1].zero;
      lg[k].ch   <= lg[k-1].ch;
    end
  end

  // Stage A: log ratio magnitude and sign
  logic              a_v, a_neg, a_zero;
  logic [LogW-1:0]   a_mag;
  logic [tadc_pkg::ChW-1:0] a_ch;
  logic [LogW:0]     diff;

  assign diff = {1'b0, lg[FracBits].f_c} - {1'b0, lg[FracBits].f_d};

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else     a_v <= lg_v[FracBits];
  end

  always_ff @(posedge clk) begin
    a_neg  <= diff[LogW];
    a_mag  <= diff[LogW] ? LogW'(-diff) : diff[LogW-1:0];
    a_zero <= lg[FracBits].zero;
    a_ch   <= lg[FracBits].ch;
  end

  // Stage B: scale by ln 2 with rounding, restore sign
  logic                   b_v, b_zero;
  logic signed [LogW:0]   b_lnq;
  logic [tadc_pkg::ChW-1:0] b_ch;
  logic [LogW+32:0]       ln_prod;
  logic [LogW-1:0]        ln_mag;

  assign ln_prod = (LogW+33)'(a_mag) * (LogW+33)'(tadc_pkg::Ln2Q32)
                 + ((LogW+33)'(1) << 31);
  assign ln_mag  = ln_prod[LogW+31:32];

  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else     b_v <= a_v;
  end

  always_ff @(posedge clk) begin
    b_lnq  <= a_neg ? -$signed({1'b0, ln_mag}) : $signed({1'b0, ln_mag});
    b_zero <= a_zero;
    b_ch   <= a_ch;
  end

  // Stage C: T0 * ln(r) and beta * 100
  logic                          c_v, c_zero;
  logic signed [tadc_pkg::TlW-1:0] c_tl;
  logic [tadc_pkg::BkW-1:0]      c_bk;
  logic [tadc_pkg::ChW-1:0]      c_ch;

  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else     c_v <= b_v;
  end

  always_ff @(posedge clk) begin
    c_tl   <= tadc_pkg::TlW'($signed({1'b0, t0}) * b_lnq);
    c_bk   <= tadc_pkg::BkW'(beta) * tadc_pkg::BkW'(100);
    c_zero <= b_zero;
    c_ch   <= b_ch;
  end

  // Stage D: denominator and T0 * beta * 100
  logic                          d_v, d_zero;
  logic signed [tadc_pkg::DqW-1:0] d_dq;
  logic [tadc_pkg::NbW-1:0]      d_nb;
  logic [tadc_pkg::ChW-1:0]      d_ch;

  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else     d_v <= c_v;
  end

  always_ff @(posedge clk) begin
    d_dq   <= $signed(tadc_pkg::DqW'({c_bk, {FracBits{1'b0}}}))
            + tadc_pkg::DqW'(c_tl);
    d_nb   <= tadc_pkg::NbW'(t0) * tadc_pkg::NbW'(c_bk);
    d_zero <= c_zero;
    d_ch   <= c_ch;
  end

  // Divider setup: rounded numerator, positive-denominator check
  tadc_pkg::div_stage_t dv   [0:QW];
  logic [QW:0]          dv_v;
  logic [tadc_pkg::NumW-1:0] num_r;

  assign num_r = tadc_pkg::NumW'({d_nb, {FracBits{1'b0}}})
               + tadc_pkg::NumW'(d_dq[tadc_pkg::DqW-2:1]);

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else     dv_v[0] <= d_v;
  end

  always_ff @(posedge clk) begin
    dv[0].r    <= tadc_pkg::RemW'(num_r);
    dv[0].dq   <= d_dq[tadc_pkg::DqW-2:0];
    dv[0].q    <= '0;
    dv[0].zero <= d_zero;
    dv[0].dpos <= !d_dq[tadc_pkg::DqW-1] && (d_dq != '0);
    dv[0].ch   <= d_ch;
  end

  // Restoring divider: one quotient bit per stage, top bit flags overflow
  for (genvar j = 1; j <= QW; j++) begin : g_div
    localparam int Bit = QW - j;
    logic [tadc_pkg::RemW-1:0] sub;
    logic                      take;
    logic [QW-1:0]             q_next;
    assign sub  = tadc_pkg::RemW'(dv[j-1].dq) << Bit;
    assign take = (dv[j-1].r >= sub);

    // Set this stage's quotient bit
    always_comb begin
      q_next      = dv[j-1].q;
      q_next[Bit] = take;
    end

    always_ff @(posedge clk) begin
      if (rst) dv_v[j] <= 1'b0;
      else     dv_v[j] <= dv_v[j-1];
    end

    always_ff @(posedge clk) begin
      dv[j].r    <= take ? dv[j-1].r - sub : dv[j-1].r;
      dv[j].dq   <= dv[j-1].dq;
      dv[j].q    <= q_next;
      dv[j].zero <= dv[j-1].zero;
      dv[j].dpos <= dv[j-1].dpos;
      dv[j].ch   <= dv[j-1].ch;
    end
  end

  // Output stage: offset to Celsius and saturate
  logic signed [tadc_pkg::TempW-1:0] temp_next;
  logic                              err_next;
  logic [QW-1:0]                     qf;

  assign qf = dv[QW].q;

  always_comb begin
    temp_next = tadc_pkg::TempW'(qf[QW-2:0]) - tadc_pkg::TempW'(tadc_pkg::KelvinOffset);
    err_next  = 1'b0;
    if (dv[QW].zero) begin
      temp_next = tadc_pkg::TempW'(tadc_pkg::TempMin);
      err_next  = 1'b1;
    end else if (!dv[QW].dpos || qf[QW-1] || (int'(qf) > tadc_pkg::TkMax)) begin
      temp_next = tadc_pkg::TempW'(tadc_pkg::TempMax);
      err_next  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dv_v[QW];
  end

  always_ff @(posedge clk) begin
    temp_centi_c <= temp_next;
    range_error  <= err_next;
    channel_out  <= dv[QW].ch;
  end

  // Checks
  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(tadc_pkg::PipeDepth) done)
    else $error("result strobe missing at fixed latency");

  a_channel_kept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(tadc_pkg::PipeDepth)
      (channel_out == $past(channel, tadc_pkg::PipeDepth)))
    else $error("channel tag not carried through");

  a_zero_code: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (adc_code == '0) |-> ##(tadc_pkg::PipeDepth)
      (range_error && (temp_centi_c == tadc_pkg::TempW'(tadc_pkg::TempMin))))
    else $error("zero code not flagged at the floor");

  a_in_range: assert property (@(posedge clk) disable iff (rst)
    done && !range_error |->
      (temp_centi_c >= tadc_pkg::TempMin) && (temp_centi_c <= tadc_pkg::TempMax))
    else $error("unflagged temperature out of range");

endmodule

// ===== dv/tb_thermistor_adc_to_temperature.sv =====
// ----------------------------------------------------------------------------
// tb_thermistor_adc_to_temperature: self-checking bench for the NTC converter
// Drives ADC codes and channel tags through the command port. A table of
// directed codes runs first, then random codes under several beta and T0
// settings. Each result beat is compared against its typed table value or
// a fixed-point beta-equation predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb_thermistor_adc_to_temperature;

  localparam logic [tadc_pkg::CfgIdxW-1:0] CfgSpare =
    tadc_pkg::CfgIdxW'(3); // no register here
  localparam longint unsigned LnTwoQ32 = 64'd2977044472;

  typedef struct {
    logic signed [tadc_pkg::TempW-1:0] temp;
    logic [tadc_pkg::ChW-1:0]          ch;
    logic                              err;
  } reading_t;

  typedef struct {
    logic [tadc_pkg::AdcBits-1:0]      code;
    logic [tadc_pkg::ChW-1:0]          ch;
    bit                                typed;
    int                                temp;
    logic                              err;
  } code_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [tadc_pkg::AdcBits-1:0] adc_code = '0;
  logic [tadc_pkg::ChW-1:0] channel = '0;
  logic done;
  logic signed [tadc_pkg::TempW-1:0] temp_centi_c;
  logic [tadc_pkg::ChW-1:0] channel_out;
  logic range_error;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tadc_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [tadc_pkg::CfgDataW-1:0] cfg_data = '0;

  // bench copy of the registers
  longint unsigned beta_k = 3435;
  longint unsigned t0_ck = 29815;

  reading_t pending_readings[$];
  int fail_count = 0;

  thermistor_adc_to_temperature dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .adc_code(adc_code), .channel(channel),
    .done(done), .temp_centi_c(temp_centi_c), .channel_out(channel_out),
    .range_error(range_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // log2 of x in Q.24 by repeated squaring of a Q1.30 mantissa
  function automatic longint unsigned log2_q24(longint unsigned x);
    longint unsigned e;
    longint unsigned m;
    longint unsigned frac;
    e = 0;
    frac = 0;
    for (int i = 0; i < 20; i++) if (x >> i > 1) e = i + 1;
    m = x << (30 - e);
    for (int i = 0; i < tadc_pkg::FracBits; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'd2147483648) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (e << tadc_pkg::FracBits) | frac;
  endfunction

  // beta equation on one code under the current registers
  function automatic reading_t beta_temperature(logic [tadc_pkg::AdcBits-1:0] code,
                                                logic [tadc_pkg::ChW-1:0] ch);
    reading_t r;
    longint l;
    longint unsigned mag;
    longint lnq;
    longint dq;
    longint unsigned num;
    longint unsigned tk;
    r.ch = ch;
    r.err = 1'b0;
    if (code == 0) begin
      r.temp = tadc_pkg::TempW'(tadc_pkg::TempMin);
      r.err = 1'b1;
    end else begin
      l = longint'(log2_q24(code))
        - longint'(log2_q24((1 << tadc_pkg::AdcBits) - code));
      mag = (l < 0) ? -l : l;
      lnq = longint'((mag * LnTwoQ32 + 64'd2147483648) >> 32);
      if (l < 0) lnq = -lnq;
      dq = longint'(beta_k) * 100 * (longint'(1) << tadc_pkg::FracBits)
         + longint'(t0_ck) * lnq;
      if (dq <= 0) begin
        r.temp = tadc_pkg::TempW'(tadc_pkg::TempMax);
        r.err = 1'b1;
      end else begin
        num = t0_ck * beta_k * 100 * (64'd1 << tadc_pkg::FracBits);
        tk = (num + (longint'(dq) >> 1)) / longint'(dq);
        if (tk > tadc_pkg::TkMax) begin
          r.temp = tadc_pkg::TempW'(tadc_pkg::TempMax);
          r.err = 1'b1;
        end else begin
          r.temp = tadc_pkg::TempW'(longint'(tk) - tadc_pkg::KelvinOffset);
        end
      end
    end
    return r;
  endfunction

  // drive one beat after a random gap and log what it should produce
  task automatic send_code(logic [tadc_pkg::AdcBits-1:0] code,
                           logic [tadc_pkg::ChW-1:0] ch,
                           bit typed, reading_t typed_val);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    adc_code <= code;
    channel <= ch;
    do @(posedge clk); while (busy);
    pending_readings.push_back(typed ? typed_val : beta_temperature(code, ch));
  endtask

  // wait for every outstanding beat, then let the pipe settle
  task automatic drain;
    start <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (tadc_pkg::PipeDepth + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [tadc_pkg::CfgIdxW-1:0] idx,
                           logic [tadc_pkg::CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == tadc_pkg::CfgBeta) beta_k = val & 16'h3FFF;
    else if (idx == tadc_pkg::CfgT0) t0_ck = val;
  endtask

  // random codes, weighted toward the ends and the middle of the scale
  task automatic random_codes(int count);
    logic [tadc_pkg::AdcBits-1:0] code;
    reading_t none;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: code = tadc_pkg::AdcBits'($urandom_range(0, 15));
        1: code = tadc_pkg::AdcBits'(4095 - $urandom_range(0, 15));
        2: code = tadc_pkg::AdcBits'(2048 + $urandom_range(0, 32) - 16);
        default: code = tadc_pkg::AdcBits'($urandom);
      endcase
      send_code(code, tadc_pkg::ChW'($urandom), 1'b0, none);
    end
  endtask

  // check each result beat against the oldest expectation
  always @(posedge clk) begin
    reading_t want;
    if (!rst && done) begin
      if (pending_readings.size() == 0) begin
        $error("result beat with nothing pending: temp %0d", temp_centi_c);
        fail_count++;
      end else begin
        want = pending_readings.pop_front();
        if (temp_centi_c !== want.temp) begin
          $error("temp_centi_c expected %0d got %0d", want.temp, temp_centi_c);
          fail_count++;
        end
        if (channel_out !== want.ch) begin
          $error("channel_out expected %0d got %0d", want.ch, channel_out);
          fail_count++;
        end
        if (range_error !== want.err) begin
          $error("range_error expected %0d got %0d", want.err, range_error);
          fail_count++;
        end
      end
    end
  end

  code_row_t code_table[] = '{
    '{12'd0,    2'd0, 1'b1, tadc_pkg::TempMin, 1'b1},  // no finite log
    '{12'd0,    2'd3, 1'b1, tadc_pkg::TempMin, 1'b1},
    '{12'd2048, 2'd1, 1'b1, 2500,    1'b0},  // ratio one gives T0
    '{12'd1,    2'd2, 1'b0, 0, 1'b0},
    '{12'd2,    2'd3, 1'b0, 0, 1'b0},
    '{12'd4095, 2'd0, 1'b0, 0, 1'b0},
    '{12'd4094, 2'd1, 1'b0, 0, 1'b0},
    '{12'd2047, 2'd2, 1'b0, 0, 1'b0},
    '{12'd2049, 2'd3, 1'b0, 0, 1'b0},
    '{12'd1024, 2'd0, 1'b0, 0, 1'b0},
    '{12'd3072, 2'd1, 1'b0, 0, 1'b0},
    '{12'd4000, 2'd2, 1'b0, 0, 1'b0},
    '{12'd100,  2'd3, 1'b0, 0, 1'b0},
    '{12'hAAA,  2'd1, 1'b0, 0, 1'b0},
    '{12'h555,  2'd2, 1'b0, 0, 1'b0},
    '{12'd3900, 2'd0, 1'b0, 0, 1'b0}
  };

  initial begin
    reading_t typed_val;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed codes at reset registers
    foreach (code_table[i]) begin
      typed_val.temp = tadc_pkg::TempW'(code_table[i].temp);
      typed_val.ch = code_table[i].ch;
      typed_val.err = code_table[i].err;
      send_code(code_table[i].code, code_table[i].ch, code_table[i].typed, typed_val);
    end
    random_codes(300);
    drain();

    // low beta and cold T0: hot codes run past 1/T = 0
    write_reg(tadc_pkg::CfgBeta, 16'd1000);
    write_reg(tadc_pkg::CfgT0, 16'd27315);
    send_code(12'd1, 2'd1, 1'b1, '{tadc_pkg::TempW'(tadc_pkg::TempMax), 2'd1, 1'b1});
    random_codes(300);
    drain();

    // high beta and hot T0
    write_reg(tadc_pkg::CfgBeta, 16'd10000);
    write_reg(tadc_pkg::CfgT0, 16'd37315);
    random_codes(300);
    drain();

    // zero beta: every code lands at a rail
    write_reg(tadc_pkg::CfgBeta, 16'd0);
    random_codes(250);
    drain();

    // writes to the spare index must change nothing, then beta and T0 are written with all ones
    write_reg(CfgSpare, 16'hFFFF);
    write_reg(tadc_pkg::CfgBeta, 16'hFFFF);
    write_reg(tadc_pkg::CfgT0, 16'hFFFF);
    random_codes(250);
    drain();

    // zero T0 with stock beta
    write_reg(tadc_pkg::CfgT0, 16'd0);
    write_reg(tadc_pkg::CfgBeta, 16'd3435);
    random_codes(200);
    drain();

    // back to stock values
    write_reg(tadc_pkg::CfgT0, 16'd29815);
    write_reg(tadc_pkg::CfgBeta, 16'd3435);
    write_reg(CfgSpare, 16'd0);
    random_codes(400);
    drain();

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
